>>> design/ease_in_out_elastic_curve_unit_assert.svh
// Assertion macros for the elastic easing curve unit.
// Needs nothing else; include it at the top of any file that asserts.
`ifndef EASE_IN_OUT_ELASTIC_CURVE_UNIT_ASSERT_SVH
`define EASE_IN_OUT_ELASTIC_CURVE_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define EIOE_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("eioe: same-cycle check failed");
// next-cycle implication
`define EIOE_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("eioe: next-cycle check failed");
`else
`define EIOE_ASSERT_IMP(name, ck, rn, ante, cons)
`define EIOE_ASSERT_NXT(name, ck, rn, ante, cons)
`endif
`endif

>>> design/eioe_pkg.sv
// Constants, types and lookup tables of the elastic easing curve unit.
// Sine and power-of-two tables are built at elaboration; no dependencies.
package eioe_pkg;

	localparam int FRAC_BITS       = 15;
	localparam int TABLE_ADDR_BITS = 8;

	localparam int PROG_W = 16;
	localparam int OUT_W  = 17;
	localparam int VAL_W  = OUT_W + 2;

	localparam int ROM_N  = 1 << TABLE_ADDR_BITS;
	localparam int QSIZE  = 1 << (TABLE_ADDR_BITS - 2);
	localparam int MAG30_W = 31;

	// phase numerator n = 160p + 19*one, sine address = floor(n / (36 * 2^(F-A)))
	localparam int PH_MUL  = 160;
	localparam int PH_OFS  = 19 << FRAC_BITS;
	localparam int N_W     = FRAC_BITS + 8;
	localparam int V_SH    = FRAC_BITS - TABLE_ADDR_BITS + 2;
	localparam int V_W     = N_W - V_SH;
	localparam int DIV_NINE = 9;
	localparam int RECIP_SH = V_W + 2;
	localparam int RECIP    = (1 << RECIP_SH) / DIV_NINE;
	localparam int PRODQ_W  = V_W + RECIP_SH - 3;
	localparam int Q_W      = V_W - 3;

	// exponent magnitude m = |20p - 10*one|
	localparam int M2_W    = FRAC_BITS + 5;
	localparam int M_W     = FRAC_BITS + 4;
	localparam int IP_W    = M_W - FRAC_BITS;
	localparam int EXP_MUL = 20;
	localparam int TEN_ONE = 10 << FRAC_BITS;

	// final product and rounding
	localparam int PROD_W  = 2 * MAG30_W;
	localparam int RND_SH  = 61 - FRAC_BITS;
	localparam int MAG_W   = PROD_W + 1 - RND_SH;

	localparam logic [PROG_W-1:0] ONE_P  = PROG_W'(1 << FRAC_BITS);
	localparam logic [PROG_W-1:0] HALF_P = PROG_W'(1 << (FRAC_BITS - 1));
	localparam logic signed [VAL_W-1:0] VAL_ONE = VAL_W'(1 << FRAC_BITS);
	localparam logic signed [VAL_W-1:0] VAL_MAX = VAL_W'(65535);
	localparam logic signed [VAL_W-1:0] VAL_MIN = -VAL_W'(65536);
	localparam logic [PROD_W:0] RND_BIAS = (PROD_W + 1)'(64'd1 << (60 - FRAC_BITS));

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] LN2_Q30     = 64'd744261118;

	typedef logic [MAG30_W-1:0] rom_t [ROM_N];

	typedef struct packed {
		logic zero;
		logic full;
		logic upper;
	} eioe_flags_t;

	// unsigned quotient by restoring long division, used only for table builds
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// sin(q * (pi/2) / QSIZE) in Q30, Taylor series through the 11th power
	function automatic logic [63:0] sin_quarter(input logic [63:0] q);
		logic [63:0] xv;
		logic [63:0] x2;
		logic [63:0] tm;
		longint acc;
		xv = (q * PI_HALF_Q30) >> (TABLE_ADDR_BITS - 2);
		x2 = (xv * xv) >> 30;
		tm = xv;
		acc = longint'(xv);
		tm = ((tm * x2) >> 30) / 64'd6;   acc = acc - longint'(tm);
		tm = ((tm * x2) >> 30) / 64'd20;  acc = acc + longint'(tm);
		tm = ((tm * x2) >> 30) / 64'd42;  acc = acc - longint'(tm);
		tm = ((tm * x2) >> 30) / 64'd72;  acc = acc + longint'(tm);
		tm = ((tm * x2) >> 30) / 64'd110; acc = acc - longint'(tm);
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > longint'(Q30_ONE)) begin
			acc = longint'(Q30_ONE);
		end
		return 64'(acc);
	endfunction

	function automatic rom_t build_sin_mag();
		rom_t tab;
		logic [63:0] quad;
		logic [63:0] qi;
		logic [63:0] idx;
		logic [63:0] v;
		for (int a = 0; a < ROM_N; a++) begin
			quad = (64'(a) >> (TABLE_ADDR_BITS - 2)) & 64'd3;
			qi = 64'(a) & 64'(QSIZE - 1);
			idx = quad[0] ? (64'(QSIZE) - qi) : qi;
			v = sin_quarter(idx);
			tab[a] = v[MAG30_W-1:0];
		end
		return tab;
	endfunction

	function automatic logic [ROM_N-1:0] build_sin_neg();
		logic [ROM_N-1:0] s;
		s = '0;
		for (int a = 0; a < ROM_N; a++) begin
			s[a] = ((a >> (TABLE_ADDR_BITS - 2)) & 3) >= 2;
		end
		return s;
	endfunction

	// 2^(-j/ROM_N) in Q30 as 2^60 over a series for exp(j*ln2/ROM_N)
	function automatic rom_t build_exp();
		rom_t tab;
		logic [63:0] z;
		logic [63:0] tm;
		logic [63:0] s;
		logic [63:0] r;
		for (int j = 0; j < ROM_N; j++) begin
			z = (64'(j) * LN2_Q30) >> TABLE_ADDR_BITS;
			tm = Q30_ONE;
			s = Q30_ONE;
			tm = ((tm * z) >> 30) / 64'd1;  s = s + tm;
			tm = ((tm * z) >> 30) / 64'd2;  s = s + tm;
			tm = ((tm * z) >> 30) / 64'd3;  s = s + tm;
			tm = ((tm * z) >> 30) / 64'd4;  s = s + tm;
			tm = ((tm * z) >> 30) / 64'd5;  s = s + tm;
			tm = ((tm * z) >> 30) / 64'd6;  s = s + tm;
			tm = ((tm * z) >> 30) / 64'd7;  s = s + tm;
			tm = ((tm * z) >> 30) / 64'd8;  s = s + tm;
			tm = ((tm * z) >> 30) / 64'd9;  s = s + tm;
			tm = ((tm * z) >> 30) / 64'd10; s = s + tm;
			tm = ((tm * z) >> 30) / 64'd11; s = s + tm;
			tm = ((tm * z) >> 30) / 64'd12; s = s + tm;
			r = div_u64(64'd1 << 60, s);
			tab[j] = r[MAG30_W-1:0];
		end
		return tab;
	endfunction

	localparam rom_t SIN_MAG = build_sin_mag();
	localparam logic [ROM_N-1:0] SIN_NEG = build_sin_neg();
	localparam rom_t EXP_TAB = build_exp();

endpackage

>>> design/eioe_progress_if.sv
// Request channel carrying the progress value into the curve unit.
// Depends on eioe_pkg for the field width.
interface eioe_progress_if;
	logic                         valid;
	logic                         ready;
	logic [eioe_pkg::PROG_W-1:0]  progress;

	modport source (output valid, output progress, input ready);
	modport sink   (input valid, input progress, output ready);
endinterface

>>> design/eioe_eased_if.sv
// Request channel carrying the eased curve value out of the curve unit.
// Depends on eioe_pkg for the field width.
interface eioe_eased_if;
	logic                               valid;
	logic                               ready;
	logic signed [eioe_pkg::OUT_W-1:0]  eased_value;

	modport source (output valid, output eased_value, input ready);
	modport sink   (input valid, input eased_value, output ready);
endinterface

>>> design/ease_in_out_elastic_curve_unit.sv
// In-out elastic easing curve: progress (Q1.15) in, eased value (Q2.15) out.
// Requests pass registered stages 1 to 6; stage 6 is the output register.
// Throughput: one request per cycle unless stalled. The sine table and the 31x31
// product own one stage each; the 2^x table and 1/9 multiply share stage 2.
// A stalled output freezes all six stages together; nothing is dropped.
// arst_n (async, active low) clears the stage valid bits only.
`include "ease_in_out_elastic_curve_unit_assert.svh"

module ease_in_out_elastic_curve_unit (
	input  logic             clk,
	input  logic             arst_n,
	eioe_progress_if.sink    sample,
	eioe_eased_if.source     result
);
	import eioe_pkg::*;

	// Pipeline advance: every stage moves when the output register is free.
	logic en;

	// stage valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	// stage flags (zero progress, full progress, upper half)
	eioe_flags_t flg_s1, flg_s2, flg_s3, flg_s4, flg_s5, flg_s6;

	// stage 1: phase numerator and exponent split
	logic [PROG_W-1:0]  p_c;
	logic [N_W-1:0]     n_c;
	logic [M2_W-1:0]    p20_c;
	logic [M2_W-1:0]    m_c;
	eioe_flags_t        flg_c;
	logic [V_W-1:0]     v_s1;
	logic [IP_W-1:0]    ip_s1;
	logic [TABLE_ADDR_BITS-1:0] j_s1;

	// stage 2: reciprocal product and power-of-two table read
	logic [PRODQ_W-1:0] prodq_s2;
	logic [V_W-1:0]     v_s2;
	logic [IP_W-1:0]    ip_s2;
	logic [MAG30_W-1:0] pexp_s2;

	// stage 3: corrected quotient gives sine address; shift power of two
	logic [Q_W-1:0]     q_est_c;
	logic [V_W-1:0]     rem_est_c;
	logic [Q_W-1:0]     q_fix_c;
	logic [V_W-1:0]     rem_fix_c;
	logic [TABLE_ADDR_BITS-1:0] addr_s3;
	logic [MAG30_W-1:0] pw_s3;

	// stage 4: sine table read
	logic [MAG30_W-1:0] smag_s4;
	logic               sneg_s4;
	logic [MAG30_W-1:0] pw_s4;

	// stage 5: product
	logic [PROD_W-1:0]  prod_s5;
	logic               neg_s5;

	// stage 6: round, sign, offset, clamp
	logic [PROD_W:0]        rnd_c;
	logic [MAG_W-1:0]       mag_c;
	logic signed [VAL_W-1:0] sval_c;
	logic signed [VAL_W-1:0] val_c;
	logic [OUT_W-1:0]       res_s6;

	assign en           = !vld_s6 || result.ready;
	assign sample.ready = en;
	assign result.valid = vld_s6;
	assign result.eased_value = res_s6;

	// ---------------- stage 1 logic ----------------
	always_comb begin
		p_c = sample.progress;
		flg_c.zero  = (p_c == '0);
		flg_c.full  = (p_c >= ONE_P);
		flg_c.upper = (p_c >= HALF_P);
		// phase in turns scaled so that the sine address is n / (36 * 2^(F-A))
		n_c   = N_W'(p_c) * N_W'(PH_MUL) + N_W'(PH_OFS);
		p20_c = M2_W'(p_c) * M2_W'(EXP_MUL);
		m_c   = flg_c.upper ? (p20_c - M2_W'(TEN_ONE)) : (M2_W'(TEN_ONE) - p20_c);
	end

	// ---------------- stage 3 logic: finish divide by nine ----------------
	always_comb begin
		q_est_c   = prodq_s2[PRODQ_W-1:RECIP_SH];
		rem_est_c = v_s2 - V_W'(q_est_c) * V_W'(DIV_NINE);
		// the reciprocal estimate is low by at most one
		if (rem_est_c >= V_W'(DIV_NINE)) begin
			q_fix_c   = q_est_c + Q_W'(1);
			rem_fix_c = rem_est_c - V_W'(DIV_NINE);
		end else begin
			q_fix_c   = q_est_c;
			rem_fix_c = rem_est_c;
		end
	end

	// ---------------- stage 6 logic ----------------
	always_comb begin
		// halve and bring Q60 to Q.F, round half away from zero (magnitude)
		rnd_c  = {1'b0, prod_s5} + RND_BIAS;
		mag_c  = rnd_c[PROD_W:RND_SH];
		sval_c = signed'({{(VAL_W - MAG_W){1'b0}}, mag_c});
		if (neg_s5) begin
			sval_c = -sval_c;
		end
		if (flg_s5.upper) begin
			sval_c = sval_c + VAL_ONE;
		end
		// endpoints override the curve
		if (flg_s5.zero) begin
			sval_c = '0;
		end else if (flg_s5.full) begin
			sval_c = VAL_ONE;
		end
		if (sval_c > VAL_MAX) begin
			val_c = VAL_MAX;
		end else if (sval_c < VAL_MIN) begin
			val_c = VAL_MIN;
		end else begin
			val_c = sval_c;
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// ---------------- payload ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: capture request
			flg_s1 <= flg_c;
			v_s1   <= n_c[N_W-1:V_SH];
			ip_s1  <= m_c[M_W-1:FRAC_BITS];
			j_s1   <= m_c[FRAC_BITS-1 -: TABLE_ADDR_BITS];

			// stage 2: multiply by reciprocal of nine, read 2^(-frac)
			flg_s2   <= flg_s1;
			prodq_s2 <= PRODQ_W'(v_s1) * PRODQ_W'(RECIP);
			v_s2     <= v_s1;
			ip_s2    <= ip_s1;
			pexp_s2  <= EXP_TAB[j_s1];

			// stage 3: sine address, apply integer part of exponent
			flg_s3  <= flg_s2;
			addr_s3 <= q_fix_c[TABLE_ADDR_BITS-1:0];
			pw_s3   <= pexp_s2 >> ip_s2;

			// stage 4: read sine
			flg_s4  <= flg_s3;
			smag_s4 <= SIN_MAG[addr_s3];
			sneg_s4 <= SIN_NEG[addr_s3];
			pw_s4   <= pw_s3;

			// stage 5: envelope times sine; lower half flips the sign
			flg_s5  <= flg_s4;
			prod_s5 <= PROD_W'(pw_s4) * PROD_W'(smag_s4);
			neg_s5  <= flg_s4.upper ? sneg_s4 : !sneg_s4;

			// stage 6: output register
			flg_s6 <= flg_s5;
			res_s6 <= val_c[OUT_W-1:0];
		end
	end

	// ---------------- assertions ----------------
	`EIOE_ASSERT_IMP(a_div_rem, clk, arst_n, vld_s2, rem_fix_c < V_W'(DIV_NINE))
	`EIOE_ASSERT_NXT(a_zero_res, clk, arst_n, vld_s5 && flg_s5.zero && en, res_s6 == '0)
	`EIOE_ASSERT_NXT(a_full_res, clk, arst_n, vld_s5 && flg_s5.full && en, res_s6 == OUT_W'(VAL_ONE))
	`EIOE_ASSERT_IMP(a_upper_pos, clk, arst_n, vld_s6 && flg_s6.upper, !res_s6[OUT_W-1])

endmodule
